### rtl/pid_controller_pos_inc_core_assert.svh
// Assertion macros shared by the PID controller RTL.
`ifndef PID_CONTROLLER_POS_INC_CORE_ASSERT_SVH
`define PID_CONTROLLER_POS_INC_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PIDPI_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define PIDPI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/pidpi_pkg.sv
// Types and codes of the PID controller core.
package pidpi_pkg;

   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_PREP    = 14'b00000000000010,
      S_ED      = 14'b00000000000100,
      S_ED_ACC  = 14'b00000000001000,
      S_DIVI_LD = 14'b00000000010000,
      S_DIVI    = 14'b00000000100000,
      S_DIVD_LD = 14'b00000001000000,
      S_DIVD    = 14'b00000010000000,
      S_DEND    = 14'b00000100000000,
      S_MQ_SET  = 14'b00001000000000,
      S_MQ_LO   = 14'b00010000000000,
      S_MQ_HI   = 14'b00100000000000,
      S_MQ_RES  = 14'b01000000000000,
      S_FIN     = 14'b10000000000000
   } state_type;

   typedef enum logic [2:0] {
      CSR_MODE       = 3'd0,
      CSR_GAIN_P     = 3'd1,
      CSR_GAIN_I     = 3'd2,
      CSR_GAIN_D     = 3'd3,
      CSR_INT_LIMIT  = 3'd4,
      CSR_OUT_LIMIT  = 3'd5
   } csr_reg_type;

   localparam logic MODE_POSITIONAL  = 1'b0;
   localparam logic MODE_INCREMENTAL = 1'b1;

   localparam int REQ_WIDTH = 96;
   localparam int RSP_WIDTH = 128;

endpackage

### rtl/pid_controller_pos_inc_core.sv
// PID controller core, positional and incremental forms, Q16.16 fixed point.
// The positional form divides the error difference times ticks per second by dt with a 64-step
//   restoring divide (skipped when dt is zero); the incremental form has no divide.
// Sum / ticks is a reciprocal multiply (four 32x32 passes); each gain product takes two.
// A new request is taken only once the last result is registered; req_tready is high only while idle.
// Reset (synchronous, active high) clears config, history and terms, sets first_ff.
module pid_controller_pos_inc_core #(
   parameter int FRAC_BITS        = 16,
   parameter int TICKS_PER_SECOND = 1000000
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: setpoint[31:0], measurement[63:32], timer_count[95:64]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pidpi_pkg::REQ_WIDTH-1:0]  req_tdata,
   // result: drive[31:0], p_term[63:32], i_term[95:64], d_term[127:96]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pidpi_pkg::RSP_WIDTH-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [2:0]                       csr_index,
   input  logic [31:0]                      csr_wdata
);

`include "pid_controller_pos_inc_core_assert.svh"

   localparam logic [31:0] TPS      = 32'(TICKS_PER_SECOND);
   localparam logic [31:0] FIRST_DT = 32'(TICKS_PER_SECOND / 100);
   localparam int          HI_SHIFT = 32 - FRAC_BITS;

   // reciprocal of ticks per second: exact quotient for any 64-bit magnitude
   localparam int           RCP_SHIFT = 64 + $clog2(TICKS_PER_SECOND);
   localparam logic [129:0] RCP_FULL  = ((130'd1 << RCP_SHIFT) + 130'(TICKS_PER_SECOND)
                                         - 130'd1) / 130'(TICKS_PER_SECOND);
   localparam logic [63:0]  RCP_LO    = RCP_FULL[63:0];
   localparam logic         RCP_HI    = RCP_FULL[64];

   // ---------------- helpers ----------------
   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sd2147483647)       return 32'sh7fffffff;
      else if (v < -36'sd2147483648) return 32'sh80000000;
      else                           return v[31:0];
   endfunction

   function automatic logic signed [31:0] clamp_sym(input logic signed [35:0] v,
                                                    input logic [30:0] lim);
      logic signed [35:0] l;
      logic signed [35:0] nl;
      l  = $signed({5'b0, lim});
      nl = -l;
      if (v > l)       return l[31:0];
      else if (v < nl) return nl[31:0];
      else             return v[31:0];
   endfunction

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      else                return s[63:0];
   endfunction

   // (|a|*|b|) >> FRAC_BITS from the two partial products, saturated, signed
   function automatic logic signed [31:0] mulq_fin(input logic [63:0] hi,
                                                   input logic [63:0] lo,
                                                   input logic neg);
      logic [63:0] lim;
      logic [63:0] m;
      lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7fff_ffff;
      if (hi > (lim >> HI_SHIFT)) begin
         m = lim;
      end else begin
         m = (hi << HI_SHIFT) + (lo >> FRAC_BITS);
         if (m > lim) m = lim;
      end
      return neg ? 32'(64'd0 - m) : m[31:0];
   endfunction

   // ---------------- registers ----------------
   pidpi_pkg::state_type state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  mq_idx_ff, mq_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // configuration
   logic               mode_ff, mode_in;
   logic signed [31:0] gain_p_ff, gain_p_in, gain_i_ff, gain_i_in, gain_d_ff, gain_d_in;
   logic [30:0]        il_ff, il_in, ol_ff, ol_in;

   // controller history
   logic               first_ff, first_in;
   logic signed [31:0] last_error_ff, last_error_in, before_ff, before_in;
   logic signed [63:0] esum_ff, esum_in;
   logic [31:0]        last_timer_ff, last_timer_in;
   logic signed [31:0] term_p_ff, term_p_in, term_i_ff, term_i_in, term_d_ff, term_d_in;

   // working payload
   logic signed [31:0] sp_ff, sp_in, ms_ff, ms_in;
   logic [31:0]        tm_ff, tm_in;
   logic signed [31:0] e_ff, e_in;
   logic [31:0]        e_mag_ff, e_mag_in;
   logic signed [32:0] diff_ff, diff_in;
   logic [31:0]        diff_mag_ff, diff_mag_in;
   logic signed [34:0] dd_ff, dd_in;
   logic [31:0]        d_ff, d_in;
   logic [63:0]        num_ff, num_in;
   logic [63:0]        dvd_ff, dvd_in;
   logic [31:0]        rem_ff, rem_in, dsr_ff, dsr_in;
   logic [129:0]       racc_ff, racc_in;
   logic signed [63:0] integ_ff, integ_in, deriv_ff, deriv_in;
   logic [63:0]        am_ff, am_in;
   logic [31:0]        bm_ff, bm_in;
   logic               neg_ff, neg_in;
   logic [63:0]        plo_ff, plo_in;
   logic signed [31:0] mq_r_ff [3];
   logic signed [31:0] mq_r_in [3];
   logic [63:0]        mul_ff, mul_in;
   logic [pidpi_pkg::RSP_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   // ---------------- shared multiplier ----------------
   logic [31:0] mx, my;
   always_comb begin
      unique case (state_ff)
         pidpi_pkg::S_ED:     begin mx = e_mag_ff;      my = d_ff;  end
         pidpi_pkg::S_ED_ACC: begin mx = diff_mag_ff;   my = TPS;   end
         // |sum| * reciprocal, one 32-bit limb pair per cycle
         pidpi_pkg::S_DIVI: begin
            mx = cnt_ff[1] ? dvd_ff[63:32] : dvd_ff[31:0];
            my = cnt_ff[0] ? RCP_LO[63:32] : RCP_LO[31:0];
         end
         pidpi_pkg::S_MQ_LO:  begin mx = am_ff[31:0];   my = bm_ff; end
         pidpi_pkg::S_MQ_HI:  begin mx = am_ff[63:32];  my = bm_ff; end
         default:             begin mx = '0;            my = '0;    end
      endcase
   end
   assign mul_in = 64'(mx) * 64'(my);

   // ---------------- shared divider step ----------------
   logic [32:0] rem_sh;
   logic        div_ge;
   logic [32:0] rem_sub;
   assign rem_sh  = {rem_ff, dvd_ff[63]};
   assign div_ge  = rem_sh >= {1'b0, dsr_ff};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   // ---------------- handshake ----------------
   logic req_fire, out_free;
   assign req_tready = state_ff == pidpi_pkg::S_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- sequencer ----------------
   logic signed [31:0] e_c;
   logic signed [32:0] diff_c;
   logic signed [63:0] prod_s;
   logic signed [63:0] a_sel;
   logic signed [31:0] b_sel;
   logic signed [31:0] mq_res;
   logic signed [35:0] sum_c;
   logic signed [31:0] drive_c;
   logic [129:0]       rprod_c;
   logic [63:0]        quot_c;
   logic               drv_pending_ff, drv_pending_in;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      mq_idx_in     = mq_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      mode_in       = mode_ff;
      gain_p_in     = gain_p_ff;
      gain_i_in     = gain_i_ff;
      gain_d_in     = gain_d_ff;
      il_in         = il_ff;
      ol_in         = ol_ff;
      first_in      = first_ff;
      last_error_in = last_error_ff;
      before_in     = before_ff;
      esum_in       = esum_ff;
      last_timer_in = last_timer_ff;
      term_p_in     = term_p_ff;
      term_i_in     = term_i_ff;
      term_d_in     = term_d_ff;
      sp_in         = sp_ff;
      ms_in         = ms_ff;
      tm_in         = tm_ff;
      e_in          = e_ff;
      e_mag_in      = e_mag_ff;
      diff_in       = diff_ff;
      diff_mag_in   = diff_mag_ff;
      dd_in         = dd_ff;
      d_in          = d_ff;
      num_in        = num_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      dsr_in        = dsr_ff;
      racc_in       = racc_ff;
      integ_in      = integ_ff;
      deriv_in      = deriv_ff;
      am_in         = am_ff;
      bm_in         = bm_ff;
      neg_in        = neg_ff;
      plo_in        = plo_ff;
      mq_r_in       = mq_r_ff;
      rsp_data_in   = rsp_data_ff;
      drv_pending_in = drv_pending_ff;

      e_c    = sat32(36'(sp_ff) - 36'(ms_ff));
      diff_c = 33'(e_c) - 33'(last_error_ff);
      prod_s = e_ff[31] ? -$signed(mul_ff) : $signed(mul_ff);
      mq_res = mulq_fin(mul_ff, plo_ff, neg_ff);
      sum_c  = 36'(term_p_ff) + 36'(term_i_ff) + 36'(term_d_ff);
      drive_c = clamp_sym(sum_c, ol_ff);
      // partial product of the previous reciprocal pass, placed at its weight
      rprod_c = (cnt_ff == 6'd4) ? (130'(mul_ff) << 64) :
                (cnt_ff == 6'd1) ? 130'(mul_ff) : (130'(mul_ff) << 32);
      quot_c  = 64'(racc_ff >> RCP_SHIFT);

      // operand pick for the gain product of this pass
      unique case ({mode_ff, mq_idx_ff})
         {pidpi_pkg::MODE_POSITIONAL, 2'd0}:  begin a_sel = 64'(e_ff);     b_sel = gain_p_ff; end
         {pidpi_pkg::MODE_POSITIONAL, 2'd1}:  begin a_sel = integ_ff;      b_sel = gain_i_ff; end
         {pidpi_pkg::MODE_POSITIONAL, 2'd2}:  begin a_sel = deriv_ff;      b_sel = gain_d_ff; end
         {pidpi_pkg::MODE_INCREMENTAL, 2'd0}: begin a_sel = 64'(diff_ff);  b_sel = gain_p_ff; end
         {pidpi_pkg::MODE_INCREMENTAL, 2'd1}: begin a_sel = 64'(e_ff);     b_sel = gain_i_ff; end
         {pidpi_pkg::MODE_INCREMENTAL, 2'd2}: begin a_sel = 64'(dd_ff);    b_sel = gain_d_ff; end
         default:                             begin a_sel = '0;            b_sel = '0;        end
      endcase

      // config writes are expected only while idle
      if (csr_we) begin
         unique case (csr_index)
            pidpi_pkg::CSR_MODE:      mode_in   = csr_wdata[0];
            pidpi_pkg::CSR_GAIN_P:    gain_p_in = $signed(csr_wdata);
            pidpi_pkg::CSR_GAIN_I:    gain_i_in = $signed(csr_wdata);
            pidpi_pkg::CSR_GAIN_D:    gain_d_in = $signed(csr_wdata);
            pidpi_pkg::CSR_INT_LIMIT: il_in     = csr_wdata[30:0];
            pidpi_pkg::CSR_OUT_LIMIT: ol_in     = csr_wdata[30:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      // result register: drive and terms of the finished request, once the slot is free
      if (drv_pending_ff && out_free) begin
         rsp_data_in    = {term_d_ff, term_i_ff, term_p_ff, drive_c};
         rsp_valid_in   = 1'b1;
         drv_pending_in = 1'b0;
         state_in       = pidpi_pkg::S_IDLE;
      end

      unique case (state_ff)
         pidpi_pkg::S_IDLE: begin
            if (req_fire) begin
               sp_in    = $signed(req_tdata[31:0]);
               ms_in    = $signed(req_tdata[63:32]);
               tm_in    = req_tdata[95:64];
               state_in = pidpi_pkg::S_PREP;
            end
         end
         pidpi_pkg::S_PREP: begin
            e_in        = e_c;
            e_mag_in    = e_c[31] ? 32'(-33'(e_c)) : 32'(e_c);
            diff_in     = diff_c;
            diff_mag_in = diff_c[32] ? 32'(-diff_c) : 32'(diff_c);
            dd_in       = 35'(e_c) - (35'(last_error_ff) <<< 1) + 35'(before_ff);
            d_in        = first_ff ? FIRST_DT : tm_ff - last_timer_ff;
            last_timer_in = tm_ff;
            first_in    = 1'b0;
            mq_idx_in   = 2'd0;
            state_in    = (mode_ff == pidpi_pkg::MODE_POSITIONAL) ?
                          pidpi_pkg::S_ED : pidpi_pkg::S_MQ_SET;
         end
         pidpi_pkg::S_ED: state_in = pidpi_pkg::S_ED_ACC;
         pidpi_pkg::S_ED_ACC: begin
            esum_in  = sat_add64(esum_ff, prod_s);
            state_in = pidpi_pkg::S_DIVI_LD;
         end
         pidpi_pkg::S_DIVI_LD: begin
            num_in   = mul_ff;                // |error difference| * ticks per second
            dvd_in   = esum_ff[63] ? 64'(-esum_ff) : 64'(esum_ff);
            // reciprocal bit 64 set: the |sum| << 64 part needs no multiply
            racc_in  = RCP_HI ? {2'b00, dvd_in, 64'd0} : '0;
            cnt_in   = '0;
            state_in = pidpi_pkg::S_DIVI;
         end
         pidpi_pkg::S_DIVI: begin
            if (cnt_ff != 6'd0) racc_in = racc_ff + rprod_c;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd4) state_in = pidpi_pkg::S_DIVD_LD;
         end
         pidpi_pkg::S_DIVD: begin
            rem_in = div_ge ? rem_sub[31:0] : rem_sh[31:0];
            dvd_in = {dvd_ff[62:0], div_ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = pidpi_pkg::S_DEND;
         end
         pidpi_pkg::S_DIVD_LD: begin
            integ_in = esum_ff[63] ? -$signed(quot_c) : $signed(quot_c);
            dvd_in   = num_ff;
            rem_in   = '0;
            dsr_in   = d_ff;
            cnt_in   = '0;
            if (d_ff == 32'd0) begin
               deriv_in = '0;                 // no time step: no derivative
               state_in = pidpi_pkg::S_MQ_SET;
            end else begin
               state_in = pidpi_pkg::S_DIVD;
            end
         end
         pidpi_pkg::S_DEND: begin
            deriv_in = diff_ff[32] ? -$signed(dvd_ff) : $signed(dvd_ff);
            state_in = pidpi_pkg::S_MQ_SET;
         end
         pidpi_pkg::S_MQ_SET: begin
            am_in    = a_sel[63] ? 64'(-a_sel) : 64'(a_sel);
            bm_in    = b_sel[31] ? 32'(-33'(b_sel)) : 32'(b_sel);
            neg_in   = a_sel[63] ^ b_sel[31];
            state_in = pidpi_pkg::S_MQ_LO;
         end
         pidpi_pkg::S_MQ_LO: state_in = pidpi_pkg::S_MQ_HI;
         pidpi_pkg::S_MQ_HI: begin
            plo_in   = mul_ff;
            state_in = pidpi_pkg::S_MQ_RES;
         end
         pidpi_pkg::S_MQ_RES: begin
            mq_r_in[mq_idx_ff] = mq_res;
            if (mq_idx_ff == 2'd2) begin
               state_in = pidpi_pkg::S_FIN;
            end else begin
               mq_idx_in = mq_idx_ff + 2'd1;
               state_in  = pidpi_pkg::S_MQ_SET;
            end
         end
         pidpi_pkg::S_FIN: begin
            if (mode_ff == pidpi_pkg::MODE_POSITIONAL) begin
               term_p_in = mq_r_ff[0];
               term_i_in = clamp_sym(36'(mq_r_ff[1]), il_ff);
               term_d_in = mq_r_ff[2];
            end else begin
               term_p_in = sat32(36'(term_p_ff) + 36'(mq_r_ff[0]));
               term_i_in = clamp_sym(36'(term_i_ff) + 36'(mq_r_ff[1]), il_ff);
               term_d_in = sat32(36'(term_d_ff) + 36'(mq_r_ff[2]));
               before_in = last_error_ff;
            end
            last_error_in  = e_ff;
            drv_pending_in = 1'b1;
            state_in       = pidpi_pkg::S_FIN;
            // wait here until the result slot frees; handled above next cycle
            if (drv_pending_ff) state_in = pidpi_pkg::S_FIN;
         end
         default: state_in = pidpi_pkg::S_IDLE;
      endcase

      // with a result pending in S_FIN, keep the terms; hold there while the slot is busy, else go idle
      if (state_ff == pidpi_pkg::S_FIN && drv_pending_ff) begin
         term_p_in     = term_p_ff;
         term_i_in     = term_i_ff;
         term_d_in     = term_d_ff;
         before_in     = before_ff;
         last_error_in = last_error_ff;
         if (out_free) begin
            state_in       = pidpi_pkg::S_IDLE;
            drv_pending_in = 1'b0;
         end else begin
            state_in       = pidpi_pkg::S_FIN;
            drv_pending_in = 1'b1;
         end
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pidpi_pkg::S_IDLE;
         cnt_ff         <= '0;
         mq_idx_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
         drv_pending_ff <= 1'b0;
         mode_ff        <= 1'b0;
         gain_p_ff      <= '0;
         gain_i_ff      <= '0;
         gain_d_ff      <= '0;
         il_ff          <= '0;
         ol_ff          <= '0;
         first_ff       <= 1'b1;
         last_error_ff  <= '0;
         before_ff      <= '0;
         esum_ff        <= '0;
         last_timer_ff  <= '0;
         term_p_ff      <= '0;
         term_i_ff      <= '0;
         term_d_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         mq_idx_ff      <= mq_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
         drv_pending_ff <= drv_pending_in;
         mode_ff        <= mode_in;
         gain_p_ff      <= gain_p_in;
         gain_i_ff      <= gain_i_in;
         gain_d_ff      <= gain_d_in;
         il_ff          <= il_in;
         ol_ff          <= ol_in;
         first_ff       <= first_in;
         last_error_ff  <= last_error_in;
         before_ff      <= before_in;
         esum_ff        <= esum_in;
         last_timer_ff  <= last_timer_in;
         term_p_ff      <= term_p_in;
         term_i_ff      <= term_i_in;
         term_d_ff      <= term_d_in;
      end
   end

   // datapath payload, no reset
   always_ff @(posedge clock) begin
      sp_ff       <= sp_in;
      ms_ff       <= ms_in;
      tm_ff       <= tm_in;
      e_ff        <= e_in;
      e_mag_ff    <= e_mag_in;
      diff_ff     <= diff_in;
      diff_mag_ff <= diff_mag_in;
      dd_ff       <= dd_in;
      d_ff        <= d_in;
      num_ff      <= num_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      dsr_ff      <= dsr_in;
      racc_ff     <= racc_in;
      integ_ff    <= integ_in;
      deriv_ff    <= deriv_in;
      am_ff       <= am_in;
      bm_ff       <= bm_in;
      neg_ff      <= neg_in;
      plo_ff      <= plo_in;
      mq_r_ff     <= mq_r_in;
      mul_ff      <= mul_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------- assertions ----------------
   `PIDPI_ASSERT_NEXT(a_accept_to_prep, clock, reset, req_fire,
      state_ff == pidpi_pkg::S_PREP, "accepted request did not enter prep")
   `PIDPI_ASSERT_IMPL(a_i_term_clamped, clock, reset, drv_pending_ff,
      ($signed(term_i_ff) <= $signed({1'b0, il_ff})) &&
      ($signed(term_i_ff) >= -$signed({1'b0, il_ff})), "i term outside its limit")
   `PIDPI_ASSERT_IMPL(a_drive_clamped, clock, reset, rsp_valid_ff,
      ($signed(rsp_data_ff[31:0]) <= $signed({1'b0, ol_ff})) &&
      ($signed(rsp_data_ff[31:0]) >= -$signed({1'b0, ol_ff})), "drive outside its limit")

endmodule

### test/pid_controller_pos_inc_core_test.sv
// Self-checking stream testbench for the positional/incremental PID controller core.
module pid_controller_pos_inc_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     FRAC_BITS  = 16;
   localparam longint TICKS      = 1000000;
   localparam int     WD_LIMIT   = 20000;  // cycles without any request or result moving
   localparam int     SETTLE     = 200;    // idle wait after each drain
   localparam int     MAX_REPORT = 10;
   localparam int     INT_MAX    = 32'sh7fffffff;
   localparam int     INT_MIN    = 32'sh80000000;

   // request fields, setpoint in the low bits
   typedef struct packed {
      logic [31:0] timer_count;
      int          measurement;
      int          setpoint;
   } pid_req_t;

   // result fields, drive in the low bits
   typedef struct packed {
      int d_term;
      int i_term;
      int p_term;
      int drive;
   } pid_rsp_t;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [pidpi_pkg::REQ_WIDTH-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [pidpi_pkg::RSP_WIDTH-1:0] rsp_tdata;
   logic                            csr_we = 1'b0;
   logic [2:0]                      csr_index = '0;
   logic [31:0]                     csr_wdata = '0;

   pid_controller_pos_inc_core #(
      .FRAC_BITS       (FRAC_BITS),
      .TICKS_PER_SECOND(int'(TICKS))
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Controller model: its own copy of registers and loop history
   // ---------------------------------------------------------------
   logic        cfg_mode = pidpi_pkg::MODE_POSITIONAL;
   int          cfg_kp = 0, cfg_ki = 0, cfg_kd = 0;
   longint      cfg_i_lim = 0, cfg_out_lim = 0;

   bit          first_step = 1'b1;
   int          last_err = 0, prev_err = 0;
   longint      err_time_sum = 0;
   logic [31:0] last_timer = '0;
   int          p_acc = 0, i_acc = 0, d_acc = 0;

   pid_rsp_t    drive_due[$];   // predicted results not yet seen
   pid_req_t    req_pending[$]; // requests waiting for the driver

   int          mismatches = 0;
   int          req_count = 0, rsp_count = 0, phase_count = 0;
   bit          quiet = 1'b0;   // no idling on either side in this phase

   function automatic int sat32(longint v);
      if (v > longint'(INT_MAX)) return INT_MAX;
      if (v < longint'(INT_MIN)) return INT_MIN;
      return int'(v);
   endfunction

   function automatic longint sat_add64(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return longint'(s);
   endfunction

   function automatic int clamp_sym(longint v, longint lim);
      if (v > lim) return int'(lim);
      if (v < -lim) return int'(-lim);
      return int'(v);
   endfunction

   // gain * x in Q16.16: exact product, magnitude truncated, saturated to 32 bits
   function automatic int gain_mul(longint x, int g);
      logic signed [127:0] sx, sg, ax, ag;
      logic [127:0]        mag, lim;
      logic [31:0]         m32;
      bit                  neg;
      sx  = x;
      sg  = g;
      ax  = (sx < 0) ? -sx : sx;
      ag  = (sg < 0) ? -sg : sg;
      neg = (x < 0) != (g < 0);
      mag = ax * ag;
      mag = mag >> FRAC_BITS;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (mag > lim) mag = lim;
      m32 = mag[31:0];
      return neg ? int'(-m32) : int'(m32);
   endfunction

   function automatic pid_rsp_t compute_drive(pid_req_t r);
      int          e;
      logic [31:0] dt;
      longint      integ, deriv, dp, dd;
      pid_rsp_t    o;
      e = sat32(longint'(r.setpoint) - longint'(r.measurement));
      dt = r.timer_count - last_timer;
      last_timer = r.timer_count;
      if (first_step) begin
         first_step = 1'b0;
         dt = 32'(TICKS / 100);
      end
      if (cfg_mode == pidpi_pkg::MODE_POSITIONAL) begin
         err_time_sum = sat_add64(err_time_sum, longint'(e) * longint'(dt));
         integ = err_time_sum / TICKS;
         deriv = 0;
         if (dt != 0) deriv = ((longint'(e) - longint'(last_err)) * TICKS) / longint'(dt);
         p_acc = gain_mul(longint'(e), cfg_kp);
         i_acc = clamp_sym(longint'(gain_mul(integ, cfg_ki)), cfg_i_lim);
         d_acc = gain_mul(deriv, cfg_kd);
      end else begin
         dp = longint'(e) - longint'(last_err);
         dd = longint'(e) - 2 * longint'(last_err) + longint'(prev_err);
         p_acc = sat32(longint'(p_acc) + gain_mul(dp, cfg_kp));
         i_acc = clamp_sym(longint'(i_acc) + gain_mul(longint'(e), cfg_ki), cfg_i_lim);
         d_acc = sat32(longint'(d_acc) + gain_mul(dd, cfg_kd));
         prev_err = last_err;
      end
      last_err = e;
      o.p_term = p_acc;
      o.i_term = i_acc;
      o.d_term = d_acc;
      o.drive  = clamp_sym(longint'(p_acc) + longint'(i_acc) + longint'(d_acc), cfg_out_lim);
      return o;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int draw_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(50, 300);
   endfunction

   // ---------------------------------------------------------------
   // Request driver: a request is taken when tvalid and tready meet
   // ---------------------------------------------------------------
   int req_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            drive_due.push_back(compute_drive(pid_req_t'(req_tdata)));
            req_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (req_pending.size() > 0) begin
               req_tdata  <= req_pending.pop_front();
               req_tvalid <= 1'b1;
               req_gap = draw_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Result monitor: random back-pressure, field compare against the
   // oldest prediction
   // ---------------------------------------------------------------
   int rsp_stall = 0;

   always @(posedge clock) begin
      pid_rsp_t got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = pid_rsp_t'(rsp_tdata);
            rsp_count++;
            if (drive_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORT)
                  $display("%0t: unexpected result drive=%h p=%h i=%h d=%h", $realtime,
                           got.drive, got.p_term, got.i_term, got.d_term);
            end else begin
               want = drive_due.pop_front();
               if (got.drive !== want.drive || got.p_term !== want.p_term ||
                   got.i_term !== want.i_term || got.d_term !== want.d_term) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORT) begin
                     $display("%0t: result %0d mismatch", $realtime, rsp_count);
                     $display("   expected drive=%h p=%h i=%h d=%h",
                              want.drive, want.p_term, want.i_term, want.d_term);
                     $display("   actual   drive=%h p=%h i=%h d=%h",
                              got.drive, got.p_term, got.i_term, got.d_term);
                  end
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall = draw_gap();
         end
      end
   end

   // watchdog: nothing moving for too long means the block hung
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WD_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
                  WD_LIMIT, drive_due.size());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   logic [31:0] tmr = 32'd0;

   // register write; only called while the block is idle
   task automatic csr_write(pidpi_pkg::csr_reg_type idx, logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         pidpi_pkg::CSR_MODE:      cfg_mode = val[0];
         pidpi_pkg::CSR_GAIN_P:    cfg_kp = int'(val);
         pidpi_pkg::CSR_GAIN_I:    cfg_ki = int'(val);
         pidpi_pkg::CSR_GAIN_D:    cfg_kd = int'(val);
         pidpi_pkg::CSR_INT_LIMIT: cfg_i_lim = longint'(val[30:0]);
         pidpi_pkg::CSR_OUT_LIMIT: cfg_out_lim = longint'(val[30:0]);
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(logic m, int kp, int ki, int kd, logic [31:0] il, logic [31:0] ol);
      csr_write(pidpi_pkg::CSR_MODE, {31'b0, m});
      csr_write(pidpi_pkg::CSR_GAIN_P, kp);
      csr_write(pidpi_pkg::CSR_GAIN_I, ki);
      csr_write(pidpi_pkg::CSR_GAIN_D, kd);
      csr_write(pidpi_pkg::CSR_INT_LIMIT, il);
      csr_write(pidpi_pkg::CSR_OUT_LIMIT, ol);
      phase_count++;
   endtask

   task automatic add_req(int sp, int ms, logic [31:0] t);
      pid_req_t r;
      r.setpoint    = sp;
      r.measurement = ms;
      r.timer_count = t;
      req_pending.push_back(r);
   endtask

   // wait for every queued request to be answered, then let the block settle
   task automatic drain();
      while (req_pending.size() > 0 || req_tvalid || drive_due.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic int rand_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return int'($urandom());
      if (r < 25) return ($urandom_range(0, 1) != 0) ? INT_MAX : INT_MIN;
      return int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
   endfunction

   function automatic int rand_gain();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return int'($urandom());
      if (r < 15) return ($urandom_range(0, 1) != 0) ? INT_MAX : INT_MIN;
      if (r < 20) return 0;
      return int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
   endfunction

   function automatic logic [31:0] rand_limit();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 32'd0;
      if (r < 30) return 32'h7fff_ffff;
      if (r < 40) return $urandom();  // top bit is dropped by the block
      return $urandom_range(0, 32'h0100_0000);
   endfunction

   task automatic add_random(int n);
      int r;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 5)       tmr = tmr;                 // zero time step
         else if (r < 10) tmr = $urandom();          // arbitrary jump, may wrap
         else             tmr = tmr + $urandom_range(1, 20000);
         add_req(rand_value(), rand_value(), tmr);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // unity P and I gains, small D gain, open limits; first request uses the fixed start step
      configure(pidpi_pkg::MODE_POSITIONAL, 32'h0001_0000, 32'h0001_0000, 32'h0000_0100,
                32'h7fff_ffff, 32'h7fff_ffff);
      add_req(32'h0002_0000, 32'h0001_0000, 32'd12345);
      add_req(32'h0002_0000, 32'h0001_8000, 32'd12345);          // same timer: no slope
      add_req(32'h0000_8000, 32'h0001_0000, 32'hffff_fff0);
      add_req(32'h0000_8000, 32'h0001_0000, 32'h0000_0010);      // timer wraps
      add_req(INT_MAX, INT_MIN, 32'h0000_0020);                  // error saturates high
      add_req(INT_MIN, INT_MAX, 32'h0000_0021);                  // and low
      add_req(0, 0, 32'h0000_0021);
      drain();

      // extreme gains with tight clamps on I and on the sum
      configure(pidpi_pkg::MODE_POSITIONAL, INT_MAX, INT_MIN, INT_MAX,
                32'h0000_8000, 32'h0001_0000);
      add_req(INT_MAX, 0, 32'h0001_0000);
      add_req(INT_MIN, 0, 32'h0002_0000);
      add_req(32'h0000_0001, 32'h0000_0000, 32'h0002_0001);
      add_req(0, INT_MAX, 32'hffff_ffff);
      drain();

      // incremental form continues on the shared error history
      configure(pidpi_pkg::MODE_INCREMENTAL, 32'h0001_0000, 32'h0000_4000, 32'h0000_8000,
                32'h0002_0000, 32'h0003_0000);
      add_req(32'h0001_0000, 0, 32'h0000_1000);
      add_req(32'h0003_0000, 0, 32'h0000_1000);
      add_req(INT_MAX, INT_MIN, 32'h8000_0000);
      add_req(INT_MIN, INT_MAX, 32'h8000_0000);
      add_req(0, 0, 32'h0000_0000);
      drain();

      // zero limits pin I and drive at zero; full-scale gains
      configure(pidpi_pkg::MODE_INCREMENTAL, INT_MIN, INT_MAX, INT_MIN, 32'h0, 32'h0);
      add_req(32'h1234_5678, 32'hedcb_a988, 32'h5555_5555);
      add_req(32'h7000_0000, 32'h9000_0000, 32'haaaa_aaaa);
      drain();

      // back to positional after incremental history
      configure(pidpi_pkg::MODE_POSITIONAL, 32'h0000_8000, 32'h0002_0000, 32'h0000_0010,
                32'h7fff_ffff, 32'h7fff_ffff);
      add_req(32'h0001_0000, 32'h0000_0000, 32'h0000_0100);
      add_req(32'h0001_0000, 32'h0002_0000, 32'h0000_0200);
      drain();

      tmr = 32'h0000_0200;
      repeat (40) begin
         quiet = ($urandom_range(0, 3) == 0);
         configure(logic'($urandom_range(0, 1)), rand_gain(), rand_gain(), rand_gain(),
                   rand_limit(), rand_limit());
         add_random(40);
         drain();
      end
      quiet = 1'b0;

      $display("checked %0d results for %0d requests over %0d register settings",
               rsp_count, req_count, phase_count);
      $display("both control forms, zero and wrapping time steps, clamps and saturation");
      if (mismatches == 0 && drive_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, drive_due.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### pid_controller_pos_inc_core.f
+incdir+rtl
rtl/pidpi_pkg.sv
rtl/pid_controller_pos_inc_core.sv
test/pid_controller_pos_inc_core_test.sv
